// ===== sv/owtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// owtsc_pkg
// Shared types, constants and functions of the scratchpad checker.
// ----------------------------------------------------------------------------
package owtsc_pkg;

	localparam int FrameBytes = 9;
	localparam int CountW     = $clog2(FrameBytes + 1);

	typedef logic [CountW-1:0] count_t;

	// byte positions within a scratchpad read
	localparam count_t POS_TEMP_LSB   = count_t'(0);
	localparam count_t POS_TEMP_MSB   = count_t'(1);
	localparam count_t POS_ALARM_HIGH = count_t'(2);
	localparam count_t POS_ALARM_LOW  = count_t'(3);
	localparam count_t POS_CONF       = count_t'(4);
	localparam count_t POS_LAST       = count_t'(FrameBytes - 1);

	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam logic [7:0] RESET_ALARM_HIGH = 8'd30;
	localparam logic [7:0] RESET_ALARM_LOW  = 8'd15;
	localparam logic [7:0] RESET_CONF       = 8'((3 << 5) | 8'h1F);

	localparam int MagW = 11;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ALARM_HIGH = 2'd0;
	localparam cfg_idx_t REG_ALARM_LOW  = 2'd1;
	localparam cfg_idx_t REG_CONF       = 2'd2;

	typedef struct packed {
		logic [7:0] alarm_high;
		logic [7:0] alarm_low;
		logic [7:0] conf;
	} cfg_t;

	typedef struct packed {
		logic               status;
		logic [15:0]        raw_code;
		logic signed [11:0] temp_sixteenths;
	} result_t;

	// reflected CRC-8, one byte
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	// two's-complement code to signed sixteenths; 16'h8000 decodes as zero
	function automatic logic signed [11:0] decode_sixteenths(input logic [15:0] code);
		logic            neg;
		logic [15:0]     c;
		logic [MagW-1:0] mag;
		logic [11:0]     mag_ext;
		neg     = code[15];
		c       = neg ? (~code + 16'd1) : code;
		mag     = c[MagW-1:0];
		mag_ext = {1'b0, mag};
		return neg ? signed'(12'd0 - mag_ext) : signed'(mag_ext);
	endfunction

endpackage

// ===== sv/owtsc_if.sv =====
// ----------------------------------------------------------------------------
// owtsc_if
// Valid/ready channels for received bytes and frame results.
// ----------------------------------------------------------------------------
interface owtsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface owtsc_out_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic [15:0]        raw_code;
	logic signed [11:0] temp_sixteenths;

	modport source (output valid, output status, output raw_code, output temp_sixteenths,
		input ready);
	modport sink   (input valid, input status, input raw_code, input temp_sixteenths,
		output ready);
endinterface

// ===== sv/owtsc_frame.sv =====
// ----------------------------------------------------------------------------
// owtsc_frame
// Frame state: byte count, CRC, field checks and the last good code.
// ----------------------------------------------------------------------------
module owtsc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic              frame_start,
	input  owtsc_pkg::cfg_t   cfg,
	output logic              res_last,
	output owtsc_pkg::result_t res
);
	import owtsc_pkg::*;

	count_t      byte_count_q;
	logic [7:0]  crc_accum_q;
	logic [15:0] temp_bytes_q;
	logic        fields_match_q;
	logic [15:0] last_good_code_q;

	count_t      cnt_eff;
	logic [7:0]  crc_eff;
	logic [15:0] temp_eff;
	logic        match_eff;
	logic [7:0]  crc_next;
	logic [15:0] temp_next;
	logic        match_next;
	logic        good;
	logic [15:0] last_good_next;

	always_comb begin
		// frame_start drops any partial frame
		cnt_eff   = frame_start ? POS_TEMP_LSB : byte_count_q;
		crc_eff   = frame_start ? 8'd0 : crc_accum_q;
		temp_eff  = frame_start ? 16'd0 : temp_bytes_q;
		match_eff = frame_start ? 1'b1 : fields_match_q;

		crc_next   = crc_byte(crc_eff, rx_byte);
		temp_next  = temp_eff;
		match_next = match_eff;
		case (cnt_eff)
			POS_TEMP_LSB:   temp_next[7:0]  = rx_byte;
			POS_TEMP_MSB:   temp_next[15:8] = rx_byte;
			POS_ALARM_HIGH: match_next = match_eff && (rx_byte == cfg.alarm_high);
			POS_ALARM_LOW:  match_next = match_eff && (rx_byte == cfg.alarm_low);
			POS_CONF:       match_next = match_eff && (rx_byte == cfg.conf);
			default:        ;
		endcase

		res_last       = (cnt_eff == POS_LAST);
		good           = (crc_next == 8'd0) && match_next;
		last_good_next = good ? temp_next : last_good_code_q;

		res.status          = ~good;
		res.raw_code        = last_good_next;
		res.temp_sixteenths = decode_sixteenths(last_good_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= POS_TEMP_LSB;
			crc_accum_q      <= 8'd0;
			temp_bytes_q     <= 16'd0;
			fields_match_q   <= 1'b1;
			last_good_code_q <= 16'd0;
		end else if (step) begin
			if (res_last) begin
				byte_count_q     <= POS_TEMP_LSB;
				crc_accum_q      <= 8'd0;
				temp_bytes_q     <= 16'd0;
				fields_match_q   <= 1'b1;
				last_good_code_q <= last_good_next;
			end else begin
				byte_count_q   <= cnt_eff + count_t'(1);
				crc_accum_q    <= crc_next;
				temp_bytes_q   <= temp_next;
				fields_match_q <= match_next;
			end
		end
	end

endmodule

// ===== sv/onewire_temp_scratchpad_checker.sv =====
// After the ninth byte's transfer, a result passes the input register
//   and then the result register; the frame state updates once per byte.
// Throughput: one byte per cycle unless the output is full and stalled.
// Reset (arst_n low) clears the byte count, CRC, field checks and last good
//   code, and loads the expected-byte registers with their defaults.
// ----------------------------------------------------------------------------
// onewire_temp_scratchpad_checker
// Checks a nine-byte 1-Wire scratchpad read and reports the temperature.
// ----------------------------------------------------------------------------
module onewire_temp_scratchpad_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  owtsc_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]          cfg_data,
	owtsc_in_if.sink            in_ch,
	owtsc_out_if.source         out_ch
);
	import owtsc_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       frame_start_s1;
	logic       advance;
	logic       res_last;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_high <= RESET_ALARM_HIGH;
			cfg_q.alarm_low  <= RESET_ALARM_LOW;
			cfg_q.conf       <= RESET_CONF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALARM_HIGH: cfg_q.alarm_high <= cfg_data;
				REG_ALARM_LOW:  cfg_q.alarm_low  <= cfg_data;
				REG_CONF:       cfg_q.conf       <= cfg_data;
				default:        ;
			endcase
		end
	end

	// hold a final byte while the result register is full and stalled
	assign advance     = valid_s1 && (!res_last || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			rx_byte_s1     <= in_ch.rx_byte;
			frame_start_s1 <= in_ch.frame_start;
		end
	end

	owtsc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (rx_byte_s1),
		.frame_start (frame_start_s1),
		.cfg         (cfg_q),
		.res_last    (res_last),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_last) begin
			out_q <= res;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = out_q.status;
	assign out_ch.raw_code        = out_q.raw_code;
	assign out_ch.temp_sixteenths = out_q.temp_sixteenths;

`ifndef SYNTHESIS
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && res_last))
		else $error("result appeared without a final byte");

	a_temp_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.temp_sixteenths == decode_sixteenths(out_q.raw_code)))
		else $error("temperature does not match raw code");

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (valid_s1 && res_last && out_valid_q && !out_ch.ready))
		else $error("input stalled without a blocked result");
`endif

endmodule

// ===== verif/tb_onewire_temp_scratchpad_checker.sv =====
// ----------------------------------------------------------------------------
// tb_onewire_temp_scratchpad_checker
// Drives scratchpad bytes into the checker and compares every frame result
// against a cycle-free scoreboard model of the CRC, field and decode logic
// or a pinned result. Starts with a short table of hand-picked bytes, then
// runs random frames over several register settings and back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_onewire_temp_scratchpad_checker;
	timeunit 1ns;
	timeprecision 1ps;

	import owtsc_pkg::*;

	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 235;
	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_LIMIT  = 2000;

	localparam cfg_idx_t REG_NONE = 2'd3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam result_t NO_READING    = '0;
	localparam result_t NO_GOOD_YET   = '{status: STATUS_BAD, raw_code: 16'h0000,
		temp_sixteenths: 12'sd0};
	localparam result_t NEG_ZERO_GOOD = '{status: STATUS_OK, raw_code: 16'h8000,
		temp_sixteenths: 12'sd0};

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
		logic       seal;
		logic       pinned;
		result_t    want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	cfg_idx_t   cfg_index;
	logic [7:0] cfg_data;

	owtsc_in_if  in_ch();
	owtsc_out_if out_ch();

	onewire_temp_scratchpad_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// scoreboard model state
	cfg_t        exp_cfg;
	count_t      frame_pos;
	logic [7:0]  frame_crc;
	logic [15:0] frame_code;
	logic        frame_ok;
	logic [15:0] good_code;

	result_t pending_readings[$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int sent_bytes;
	logic need_restart;

	// bad field byte after reset, a cut-off frame, then a restart carrying
	// a good negative-zero reading
	stim_row_t directed_rows [0:20] = '{
		'{8'hFF, 1'b1, 1'b0, 1'b0, NO_READING},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
		'{RESET_ALARM_LOW, 1'b0, 1'b0, 1'b0, NO_READING},
		'{RESET_CONF, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h10, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h00, 1'b0, 1'b0, 1'b1, NO_GOOD_YET},
		'{8'h55, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'hAA, 1'b0, 1'b0, 1'b0, NO_READING},
		'{RESET_ALARM_HIGH, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h00, 1'b1, 1'b0, 1'b0, NO_READING},
		'{8'h80, 1'b0, 1'b0, 1'b0, NO_READING},
		'{RESET_ALARM_HIGH, 1'b0, 1'b0, 1'b0, NO_READING},
		'{RESET_ALARM_LOW, 1'b0, 1'b0, 1'b0, NO_READING},
		'{RESET_CONF, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h0C, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h10, 1'b0, 1'b0, 1'b0, NO_READING},
		'{8'h00, 1'b0, 1'b1, 1'b1, NEG_ZERO_GOOD}
	};

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// reflected CRC-8, shifted one bit at a time, LSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb  = crc[0] ^ b[i];
			crc = {1'b0, crc[7:1]};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	function automatic logic signed [11:0] to_sixteenths(input logic [15:0] code);
		logic [10:0] mag;
		// only the low 11 bits of the negated code survive the mask
		mag = code[15] ? (~code[10:0] + 11'd1) : code[10:0];
		return code[15] ? 12'(-{1'b0, mag}) : 12'({1'b0, mag});
	endfunction

	function automatic void clear_frame();
		frame_pos  = '0;
		frame_crc  = 8'h00;
		frame_code = 16'h0000;
		frame_ok   = 1'b1;
	endfunction

	task automatic track_scratchpad(input logic [7:0] b, input logic fs,
		output logic done, output result_t r);
		logic ok;
		done = 1'b0;
		r    = '0;
		if (fs) begin
			clear_frame();
		end
		frame_crc = crc8_step(frame_crc, b);
		case (frame_pos)
			POS_TEMP_LSB: frame_code[7:0] = b;
			POS_TEMP_MSB: frame_code[15:8] = b;
			POS_ALARM_HIGH: if (b != exp_cfg.alarm_high) frame_ok = 1'b0;
			POS_ALARM_LOW: if (b != exp_cfg.alarm_low) frame_ok = 1'b0;
			POS_CONF: if (b != exp_cfg.conf) frame_ok = 1'b0;
			default: ;
		endcase
		if (frame_pos == POS_LAST) begin
			ok = (frame_crc == 8'h00) && frame_ok;
			if (ok) begin
				good_code = frame_code;
			end
			done              = 1'b1;
			r.status          = ok ? STATUS_OK : STATUS_BAD;
			r.raw_code        = good_code;
			r.temp_sixteenths = to_sixteenths(good_code);
			clear_frame();
		end else begin
			frame_pos = frame_pos + count_t'(1);
		end
	endtask

	// called and returns at a falling edge
	task automatic push_byte(input logic [7:0] b, input logic fs, input logic pinned,
		input result_t want);
		logic    done;
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.rx_byte     <= b;
		in_ch.frame_start <= fs;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		track_scratchpad(b, fs, done, r);
		if (done) begin
			pending_readings.push_back(pinned ? want : r);
		end
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ALARM_HIGH: exp_cfg.alarm_high = v;
			REG_ALARM_LOW: exp_cfg.alarm_low = v;
			REG_CONF: exp_cfg.conf = v;
			default: ;
		endcase
	endtask

	// hold the sender until every reading is back
	task automatic wait_readings();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_readings.size() != 0);
	endtask

	task automatic settle();
		wait_readings();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly well-formed frames; some with a wrong field, a bad CRC or cut short
	task automatic send_frame(input logic force_start, output logic cut);
		logic [15:0] specials [0:5] = '{16'h0000, 16'h8000, 16'hFFFF, 16'h07FF,
			16'hF801, 16'h8001};
		logic [15:0] code;
		logic [7:0]  b;
		int          fault;
		int          bad_pos;
		int          cut_at;
		code    = ($urandom_range(3) == 0) ? specials[$urandom_range(5)] : 16'($urandom);
		fault   = $urandom_range(99);
		bad_pos = $urandom_range(2, 4);
		cut_at  = (fault >= 90) ? $urandom_range(1, FrameBytes - 1) : FrameBytes;
		for (int i = 0; i < cut_at; i++) begin
			case (i)
				0: b = code[7:0];
				1: b = code[15:8];
				2: b = exp_cfg.alarm_high;
				3: b = exp_cfg.alarm_low;
				4: b = exp_cfg.conf;
				FrameBytes - 1: b = frame_crc;
				default: b = 8'($urandom);
			endcase
			if (fault >= 70 && fault < 80 && i == bad_pos) begin
				b = b ^ 8'($urandom_range(1, 255));
			end
			if (fault >= 80 && fault < 90 && i == FrameBytes - 1) begin
				b = b ^ 8'($urandom_range(1, 255));
			end
			push_byte(b, (i == 0) && (force_start || $urandom_range(1) == 1), 1'b0,
				NO_READING);
		end
		cut = (cut_at < FrameBytes);
	endtask

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_reading
		result_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected reading status=%0d raw=%h temp=%0d", $time,
					out_ch.status, out_ch.raw_code, out_ch.temp_sixteenths);
			end else begin
				want = pending_readings.pop_front();
				if (want.status !== out_ch.status || want.raw_code !== out_ch.raw_code ||
					want.temp_sixteenths !== out_ch.temp_sixteenths) begin
					mismatches++;
					$display("%0t: expected status=%0d raw=%h temp=%0d, got status=%0d raw=%h temp=%0d",
						$time, want.status, want.raw_code, want.temp_sixteenths,
						out_ch.status, out_ch.raw_code, out_ch.temp_sixteenths);
				end
			end
		end
	end

	// end the run once nothing has moved for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [7:0] b;
		cfg_t       cfg_now;
		logic       paused;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_ALARM_HIGH;
		cfg_data          = 8'h00;
		in_ch.valid       = 1'b0;
		in_ch.rx_byte     = 8'h00;
		in_ch.frame_start = 1'b0;
		out_ch.ready      = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		mismatches        = 0;
		sent_bytes        = 0;
		need_restart      = 1'b0;
		exp_cfg           = '{alarm_high: RESET_ALARM_HIGH, alarm_low: RESET_ALARM_LOW,
			conf: RESET_CONF};
		good_code         = 16'h0000;
		clear_frame();

		// hold reset, then release it at a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// writes to the spare index must leave the defaults alone
		write_reg(REG_NONE, 8'h00);
		foreach (directed_rows[i]) begin
			b = directed_rows[i].seal ? frame_crc : directed_rows[i].rx_byte;
			push_byte(b, directed_rows[i].frame_start, directed_rows[i].pinned,
				directed_rows[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: cfg_now = '{alarm_high: RESET_ALARM_HIGH, alarm_low: RESET_ALARM_LOW,
					conf: RESET_CONF};
				1: cfg_now = '0;
				2: cfg_now = '1;
				5: cfg_now = '{alarm_high: 8'hFF, alarm_low: 8'h00, conf: 8'h80};
				default: cfg_now = 24'($urandom);
			endcase
			write_reg(REG_CONF, cfg_now.conf);
			write_reg(REG_NONE, 8'($urandom));
			write_reg(REG_ALARM_LOW, cfg_now.alarm_low);
			write_reg(REG_ALARM_HIGH, cfg_now.alarm_high);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			sent_bytes = 0;
			paused     = 1'b0;
			while (sent_bytes < PHASE_BYTES) begin
				send_frame(need_restart, need_restart);
				if (!paused && sent_bytes >= PHASE_BYTES / 2) begin
					wait_readings();
					paused = 1'b1;
				end
			end
		end

		settle();
		if (mismatches == 0 && pending_readings.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
